// ===== design/tabt_pkg.sv =====
package tabt_pkg;

    // action codes
    typedef enum logic [2:0] {
        ACT_BAN   = 3'd0,
        ACT_UNBAN = 3'd1,
        ACT_QUERY = 3'd2,
        ACT_SWEEP = 3'd3,
        ACT_CLEAR = 3'd4
    } action_t;

    // status codes
    localparam logic [1:0] STAT_DONE          = 2'd0;
    localparam logic [1:0] STAT_NOT_SHORTENED = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND     = 2'd2;
    localparam logic [1:0] STAT_FULL          = 2'd3;

    localparam int unsigned TIME_W    = 48;
    localparam int unsigned DUR_W     = 32;
    localparam int unsigned REMOVED_W = 7;

    localparam logic [TIME_W-1:0]    TIME_MAX      = {TIME_W{1'b1}};
    localparam logic [REMOVED_W-1:0] REMOVED_MAX   = {REMOVED_W{1'b1}};
    localparam logic [DUR_W-1:0]     DEFAULT_BAN_S = 32'd86400;

    typedef struct packed {
        logic [2:0]        action;
        logic [63:0]       address_high;
        logic [63:0]       address_low;
        logic [DUR_W-1:0]  duration;
        logic [TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 is_banned;
        logic [TIME_W-1:0]    end_time;
        logic [REMOVED_W-1:0] removed;
        logic                 changed;
    } out_item_t;

    // one table slot as held in the entry ram
    typedef struct packed {
        logic              valid;
        logic [63:0]       addr_high;
        logic [63:0]       addr_low;
        logic [TIME_W-1:0] end_time;
    } entry_t;

endpackage

// ===== design/timed_address_ban_table_top.sv =====
// Ban table of 128-bit addresses with expiry times, held in one entry ram of
// TABLE_ENTRIES slots. Every item walks the whole table through the ram's
// single read port with one shared address and expiry comparator, then a drain
// step, and the result is loaded once the output register is free (an unknown
// action skips the walk); the next item is taken only after that, and
// in_ready is low meanwhile. The result sits in an output register, so the
// next item may be taken while the result waits. After reset a clearing pass
// over every slot empties the ram before the first item is taken;
// configuration writes are taken at any time.
module timed_address_ban_table_top
    import tabt_pkg::*;
    #(
        parameter int unsigned TABLE_ENTRIES = 64
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             in_valid,
        output logic             in_ready,
        input  in_item_t         in_data,
        output logic             out_valid,
        input  logic             out_ready,
        output out_item_t        out_data,
        input  logic             cfg_we,
        input  logic [DUR_W-1:0] cfg_wdata
    );

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [DUR_W-1:0]     dflt_reg;
    logic [2:0]           act_reg;
    logic [63:0]          hi_reg;
    logic [63:0]          lo_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    newend_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     found_idx_reg;
    logic [TIME_W-1:0]    found_end_reg;
    logic                 free_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic [REMOVED_W-1:0] count_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic [DUR_W-1:0]     dur_eff;
    logic [TIME_W:0]      end_sum;
    logic [TIME_W-1:0]    newend_next;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;
    logic                 hit;
    logic                 expired;
    logic                 drop;
    logic                 fin_go;
    out_item_t            res_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign fin_go    = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // new end time, saturated at the time maximum
    assign dur_eff     = (in_data.duration != '0) ? in_data.duration : dflt_reg;
    assign end_sum     = {1'b0, in_data.now} + (TIME_W + 1)'(dur_eff);
    assign newend_next = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];

    // shared compare unit on the slot returned by the ram
    assign rd_entry = entry_t'(ram_rdata);
    assign hit      = rd_entry.valid && (rd_entry.addr_high == hi_reg)
                      && (rd_entry.addr_low == lo_reg);
    assign expired  = now_reg > rd_entry.end_time;
    assign drop     = pend_reg && rd_entry.valid
                      && ((act_reg == ACT_CLEAR) || ((act_reg == ACT_SWEEP) && expired));

    // table walk read port
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_raddr = cnt_reg;

    // write port: clearing pass, sweep/clear drops, ban/unban update
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (state_reg == ST_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
        end
        else if (drop)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_reg;
        end
        else if (fin_go)
        begin
            case (act_reg)
                ACT_BAN:
                begin
                    if (found_reg)
                    begin
                        ram_we = (found_end_reg < newend_reg);
                        ram_waddr = found_idx_reg;
                    end
                    else
                    begin
                        ram_we = free_reg;
                        ram_waddr = free_idx_reg;
                    end
                    ram_wdata = '{valid: 1'b1, addr_high: hi_reg, addr_low: lo_reg,
                                  end_time: newend_reg};
                end
                ACT_UNBAN:
                begin
                    ram_we    = found_reg;
                    ram_waddr = found_idx_reg;
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // result of the finished walk
    always_comb
    begin
        res_next = '0;
        case (act_reg)
            ACT_BAN:
            begin
                if (found_reg)
                begin
                    if (found_end_reg >= newend_reg)
                    begin
                        res_next.status   = STAT_NOT_SHORTENED;
                        res_next.end_time = found_end_reg;
                    end
                    else
                    begin
                        res_next.end_time = newend_reg;
                        res_next.changed  = 1'b1;
                    end
                end
                else if (free_reg)
                begin
                    res_next.end_time = newend_reg;
                    res_next.changed  = 1'b1;
                end
                else
                begin
                    res_next.status = STAT_FULL;
                end
            end
            ACT_UNBAN:
            begin
                if (found_reg)
                begin
                    res_next.end_time = found_end_reg;
                    res_next.changed  = 1'b1;
                end
                else
                begin
                    res_next.status = STAT_NOT_FOUND;
                end
            end
            ACT_QUERY:
            begin
                if (found_reg)
                begin
                    res_next.end_time  = found_end_reg;
                    res_next.is_banned = !(now_reg > found_end_reg);
                end
                else
                begin
                    res_next.status = STAT_NOT_FOUND;
                end
            end
            ACT_SWEEP, ACT_CLEAR:
            begin
                res_next.removed = count_reg;
                res_next.changed = (count_reg != '0);
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // sequencer, walk state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            dflt_reg      <= DEFAULT_BAN_S;
            act_reg       <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            now_reg       <= '0;
            newend_reg    <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            found_end_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dflt_reg <= cfg_wdata;
            end

            // compare stage on the slot read in the previous cycle
            pend_reg     <= ram_re;
            pend_idx_reg <= ram_raddr;
            if (pend_reg)
            begin
                if (hit && !found_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= pend_idx_reg;
                    found_end_reg <= rd_entry.end_time;
                end
                if ((!rd_entry.valid || expired) && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= pend_idx_reg;
                end
                if (drop && (count_reg != REMOVED_MAX))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            // output register: load a finished result, else empty on transfer
            if (fin_go)
            begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT:
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg    <= in_data.action;
                        hi_reg     <= in_data.address_high;
                        lo_reg     <= in_data.address_low;
                        now_reg    <= in_data.now;
                        newend_reg <= newend_next;
                        found_reg  <= 1'b0;
                        free_reg   <= 1'b0;
                        count_reg  <= '0;
                        cnt_reg    <= '0;
                        if (in_data.action inside {ACT_BAN, ACT_UNBAN, ACT_QUERY,
                                                   ACT_SWEEP, ACT_CLEAR})
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (fin_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tabt_ram
        #(
            .WIDTH (ENTRY_W),
            .DEPTH (TABLE_ENTRIES)
        )
        u_entry_ram
        (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (ram_re),
            .raddr (ram_raddr),
            .rdata (ram_rdata)
        );

`ifndef SYNTHESIS
    // a new result only appears out of the finish step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the finish step");

    // walk never writes the slot it is reading
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("entry ram read and write at the same slot");

    // one item at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready straight after a transfer");

    // removals always count as a change
    a_removed_changed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.removed != '0)) |-> out_data.changed)
        else $error("entries removed without change flag");
`endif

endmodule

// ===== design/tabt_ram.sv =====
module tabt_ram
    #(
        parameter int unsigned WIDTH = 8,
        parameter int unsigned DEPTH = 64
    )
    (
        input  logic                                    clk,
        input  logic                                    we,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
        input  logic [WIDTH-1:0]                        wdata,
        input  logic                                    re,
        input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
        output logic [WIDTH-1:0]                        rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
